FILE: rtl/assert_macros.svh
// Assertion macros shared by the ramp timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/srst_pkg.sv
// Types and constants of the stepper ramp step timer.
package srst_pkg;

  localparam int DELAY_W = 32;
  localparam int COUNT_W = 32;
  localparam int POS_W   = 32;
  localparam int CFG_W   = 32;
  localparam int DVD_W   = DELAY_W + 1;   // dividend 2*d
  localparam int DVS_W   = COUNT_W + 2;   // divisor 4*n+1 or 4*n-1

  localparam logic [DELAY_W-1:0] START_DELAY_RST = DELAY_W'(65535);
  localparam logic [DELAY_W-1:0] INSTANT_THR_RST = '1;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_START    = 2'd1,
    CMD_RETARGET = 2'd2
  } cmd_e;

  typedef enum logic {
    CFG_START_DELAY = 1'b0,
    CFG_INSTANT_THR = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_POST,
    ST_OUT
  } state_e;

  typedef struct packed {
    cmd_e                command;
    logic [DELAY_W-1:0]  target_delay;
    logic [COUNT_W-1:0]  target_steps;
    logic                run_request;
    logic                direction;
  } in_item_t;

  typedef struct packed {
    logic                    step_pulse;
    logic [DELAY_W-1:0]      next_delay;
    logic signed [POS_W-1:0] position;
    logic [COUNT_W-1:0]      steps_done;
    logic [COUNT_W-1:0]      ramp_count;
    logic                    at_target;
    logic                    finished;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/stepper_ramp_step_timer_top.sv
// Top level of the stepper ramp step timer: command sequencer, state and config.
//
// Stepper speed-ramp generator using the linear-acceleration recurrence
// d -= 2d/(4n+1) on ramp up and d += 2d/(4n-1) on ramp down, clamped at the
// goal delay. One item is handled at a time: in_ready_o is high only while the
// block is idle. Start, retarget, unused commands, ticks while finished and
// instant-stop ticks go from the execute state straight to the output state;
// other ticks that need no division pass through the post state first; ramp
// ticks also wait in the divide state for the bit-serial divider (33 quotient
// bits, one per cycle), whose done strobe updates the delay before the post
// state checks for deceleration. The result holds until it is transferred,
// after which the next item can be taken in the following cycle. Configuration
// writes take effect at once and are meant for idle periods.
`include "assert_macros.svh"

module stepper_ramp_step_timer_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [srst_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  srst_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output srst_pkg::out_item_t  out_data_o
);

  localparam int DELAY_W = srst_pkg::DELAY_W;
  localparam int COUNT_W = srst_pkg::COUNT_W;
  localparam int POS_W   = srst_pkg::POS_W;
  localparam int DVD_W   = srst_pkg::DVD_W;

  srst_pkg::state_e state_q, state_d;

  logic [DELAY_W-1:0] start_delay_q, start_delay_d;
  logic [DELAY_W-1:0] inst_thr_q, inst_thr_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [DELAY_W-1:0] goal_delay_q, goal_delay_d;
  logic [COUNT_W-1:0] goal_steps_q, goal_steps_d;
  logic [COUNT_W-1:0] ramp_q, ramp_d;
  logic [COUNT_W-1:0] steps_q, steps_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               run_q, run_d;
  logic               dir_q, dir_d;
  logic               reached_q, reached_d;
  logic               stopped_q, stopped_d;
  logic               pulse_q, pulse_d;
  logic               down_q, down_d;
  srst_pkg::in_item_t item_q, item_d;

  srst_pkg::div_req_t div_req;
  srst_pkg::div_rsp_t div_rsp;

  logic               tick_go;
  logic               inst_zone;
  logic               go_up;
  logic               go_down;
  logic               need_div;
  logic [COUNT_W-1:0] ramp_inc;
  logic [COUNT_W-1:0] ramp_dec;
  logic [COUNT_W-1:0] ramp_dec2;
  logic [DVD_W-1:0]   up_diff;
  logic [DVD_W-1:0]   down_sum;
  logic [COUNT_W:0]   decel_sum;

  // Tick classification, evaluated against the state before the tick.
  always_comb begin
    tick_go   = (state_q == srst_pkg::ST_EXEC) && (item_q.command == srst_pkg::CMD_TICK)
                && !stopped_q;
    inst_zone = (goal_delay_q >= inst_thr_q) && (delay_q >= inst_thr_q);
    go_up     = !inst_zone && (delay_q > goal_delay_q);
    go_down   = !inst_zone && (delay_q < goal_delay_q);
    ramp_inc  = ramp_q + COUNT_W'(1);
    ramp_dec  = (ramp_q != '0) ? ramp_q - COUNT_W'(1) : '0;
    ramp_dec2 = ramp_dec - COUNT_W'(1);
    need_div  = tick_go && (go_up || (go_down && (ramp_dec != '0)));
    up_diff   = {1'b0, delay_q} - div_rsp.quotient;
    down_sum  = {1'b0, delay_q} + div_rsp.quotient;
    decel_sum = {1'b0, steps_q} + {1'b0, ramp_q};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srst_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = srst_pkg::ST_EXEC;
      end
      srst_pkg::ST_EXEC: begin
        if (!tick_go) begin
          state_d = srst_pkg::ST_OUT;
        end else if (inst_zone && !run_q) begin
          state_d = srst_pkg::ST_OUT;
        end else if (need_div) begin
          state_d = srst_pkg::ST_DIV;
        end else begin
          state_d = srst_pkg::ST_POST;
        end
      end
      srst_pkg::ST_DIV: begin
        if (div_rsp.done) state_d = srst_pkg::ST_POST;
      end
      srst_pkg::ST_POST: state_d = srst_pkg::ST_OUT;
      srst_pkg::ST_OUT: begin
        if (out_ready_i) state_d = srst_pkg::ST_IDLE;
      end
      default: state_d = srst_pkg::ST_IDLE;
    endcase
  end

  // Handshake and divider control.
  always_comb begin
    in_ready_o       = (state_q == srst_pkg::ST_IDLE);
    out_valid_o      = (state_q == srst_pkg::ST_OUT);
    div_req.start    = need_div;
    div_req.dividend = {delay_q, 1'b0};
    div_req.divisor  = go_up ? {ramp_inc, 2'b01} : {ramp_dec2, 2'b11};
  end

  // Datapath and configuration.
  always_comb begin
    start_delay_d = start_delay_q;
    inst_thr_d    = inst_thr_q;
    delay_d       = delay_q;
    goal_delay_d  = goal_delay_q;
    goal_steps_d  = goal_steps_q;
    ramp_d        = ramp_q;
    steps_d       = steps_q;
    pos_d         = pos_q;
    run_d         = run_q;
    dir_d         = dir_q;
    reached_d     = reached_q;
    stopped_d     = stopped_q;
    pulse_d       = pulse_q;
    down_d        = down_q;
    item_d        = item_q;

    if (cfg_we_i) begin
      case (srst_pkg::cfg_idx_e'(cfg_idx_i))
        srst_pkg::CFG_START_DELAY: start_delay_d = cfg_data_i[DELAY_W-1:0];
        srst_pkg::CFG_INSTANT_THR: inst_thr_d    = cfg_data_i[DELAY_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      srst_pkg::ST_IDLE: begin
        if (in_valid_i) item_d = in_data_i;
      end
      srst_pkg::ST_EXEC: begin
        pulse_d = 1'b0;
        case (item_q.command)
          srst_pkg::CMD_START: begin
            goal_delay_d = item_q.target_delay;
            goal_steps_d = item_q.target_steps;
            run_d        = item_q.run_request;
            dir_d        = item_q.direction;
            steps_d      = '0;
            ramp_d       = '0;
            delay_d      = start_delay_q;
            reached_d    = 1'b0;
            stopped_d    = 1'b0;
          end
          srst_pkg::CMD_RETARGET: begin
            goal_delay_d = item_q.target_delay;
            run_d        = item_q.run_request;
            reached_d    = (delay_q == item_q.target_delay);
          end
          srst_pkg::CMD_TICK: begin
            if (!stopped_q) begin
              pulse_d = 1'b1;
              steps_d = steps_q + COUNT_W'(1);
              pos_d   = dir_q ? pos_q - POS_W'(1) : pos_q + POS_W'(1);
              down_d  = go_down;
              if (inst_zone) begin
                if (!run_q) begin
                  // instant stop
                  ramp_d    = '0;
                  delay_d   = start_delay_q;
                  reached_d = 1'b1;
                  stopped_d = 1'b1;
                end else if (delay_q != goal_delay_q) begin
                  ramp_d    = COUNT_W'(1);
                  delay_d   = goal_delay_q;
                  reached_d = 1'b1;
                end
              end else if (go_up) begin
                ramp_d = ramp_inc;
              end else if (go_down) begin
                ramp_d = ramp_dec;
                // last ramp step: drop straight to the start delay
                if (ramp_dec == '0) delay_d = start_delay_q;
              end
            end
          end
          default: ;
        endcase
      end
      srst_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (!down_q) begin
            if (up_diff <= {1'b0, goal_delay_q}) begin
              delay_d   = goal_delay_q;
              reached_d = 1'b1;
            end else begin
              delay_d = up_diff[DELAY_W-1:0];
            end
          end else begin
            if (down_sum >= {1'b0, goal_delay_q}) begin
              delay_d   = goal_delay_q;
              reached_d = 1'b1;
            end else begin
              delay_d = down_sum[DELAY_W-1:0];
            end
          end
        end
      end
      srst_pkg::ST_POST: begin
        if (ramp_q == '0) begin
          reached_d = 1'b1;
          stopped_d = 1'b1;
        end else if (run_q && (decel_sum >= {1'b0, goal_steps_q})) begin
          // start deceleration toward the start delay
          run_d        = 1'b0;
          goal_delay_d = start_delay_q;
          reached_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= srst_pkg::ST_IDLE;
      start_delay_q <= srst_pkg::START_DELAY_RST;
      inst_thr_q    <= srst_pkg::INSTANT_THR_RST;
      delay_q       <= srst_pkg::START_DELAY_RST;
      goal_delay_q  <= '0;
      goal_steps_q  <= '0;
      ramp_q        <= '0;
      steps_q       <= '0;
      pos_q         <= '0;
      run_q         <= 1'b0;
      dir_q         <= 1'b0;
      reached_q     <= 1'b0;
      stopped_q     <= 1'b1;
      pulse_q       <= 1'b0;
      down_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      start_delay_q <= start_delay_d;
      inst_thr_q    <= inst_thr_d;
      delay_q       <= delay_d;
      goal_delay_q  <= goal_delay_d;
      goal_steps_q  <= goal_steps_d;
      ramp_q        <= ramp_d;
      steps_q       <= steps_d;
      pos_q         <= pos_d;
      run_q         <= run_d;
      dir_q         <= dir_d;
      reached_q     <= reached_d;
      stopped_q     <= stopped_d;
      pulse_q       <= pulse_d;
      down_q        <= down_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  srst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    out_data_o.step_pulse = pulse_q;
    out_data_o.next_delay = delay_q;
    out_data_o.position   = $signed(pos_q);
    out_data_o.steps_done = steps_q;
    out_data_o.ramp_count = ramp_q;
    out_data_o.at_target  = reached_q;
    out_data_o.finished   = stopped_q;
  end

  `ASSERT_IMPLY(a_div_only_on_tick, clk_i, rst_ni, state_q == srst_pkg::ST_DIV, pulse_q && !stopped_q)
  `ASSERT_IMPLY(a_finish_zero_ramp, clk_i, rst_ni, out_valid_o && pulse_q && stopped_q, ramp_q == '0)
  `ASSERT_IMPLY(a_reached_at_goal, clk_i, rst_ni, out_valid_o && pulse_q && !stopped_q && reached_q, delay_q == goal_delay_q)

endmodule

FILE: rtl/srst_div.sv
// Restoring divider, one quotient bit per cycle, shared by both ramp directions.
`include "assert_macros.svh"

module srst_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srst_pkg::div_req_t req_i,
  output srst_pkg::div_rsp_t rsp_o
);

  localparam int DVD_W = srst_pkg::DVD_W;
  localparam int DVS_W = srst_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quot_q, quot_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_q, quot_q[DVD_W-1]};
    fits    = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      rem_d  = '0;
      quot_d = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract where the divisor fits
      rem_d  = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quot_d = {quot_q[DVD_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

  `ASSERT_IMPLY(a_start_when_free, clk_i, rst_ni, req_i.start, !busy_q)
  `ASSERT_IMPLY(a_done_not_busy, clk_i, rst_ni, done_q, !busy_q && !req_i.start)
  `ASSERT_NEXT(a_last_step_done, clk_i, rst_ni, busy_q && cnt_q == CNT_W'(1), done_q)

endmodule
